// ===== src/bres_pkg.sv =====
// shared constants and types for the byte range extent splitter
`default_nettype none

package bres_pkg;

	localparam int TABLE_DEPTH  = 16;
	localparam int OFFSET_WIDTH = 48;
	localparam int ID_W         = 64;
	localparam int CFG_W        = 5;
	localparam int END_W        = OFFSET_WIDTH + 1;
	localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int N_W          = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W      = ID_W + 2 * OFFSET_WIDTH;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SPLIT = 1'b1;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] seg_entry;
		logic [ID_W-1:0]  seg_block_id;
		logic [END_W-1:0] seg_start;
		logic [END_W-1:0] seg_end;
		logic             status;
		logic             last;
	} result_t;

endpackage

`default_nettype wire

// ===== src/bres_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module bres_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 160,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/bres_scan.sv =====
// scan sequencer: walks the extent table and builds segment results
`default_nettype none

module bres_scan (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] range_start,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] range_length,
	input  wire logic [bres_pkg::CFG_W-1:0]        count,
	output logic                                   idle,
	output logic      [bres_pkg::IDX_W-1:0]        rd_addr,
	input  wire logic [bres_pkg::ENTRY_W-1:0]      rd_data,
	output logic                                   res_valid,
	output bres_pkg::result_t                      res,
	input  wire logic                              res_take
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                        state_q;
	logic [bres_pkg::END_W-1:0]    pos_q;
	logic [bres_pkg::END_W-1:0]    rend_q;
	logic [bres_pkg::N_W-1:0]      n_q;
	logic [bres_pkg::N_W-1:0]      idx_q;
	logic                          vld_s1;
	logic [bres_pkg::IDX_W-1:0]    ent_s1;
	bres_pkg::result_t             res_q;

	logic [bres_pkg::N_W-1:0]          n_next;
	logic                              issue;
	logic [bres_pkg::ID_W-1:0]         rd_id;
	logic [bres_pkg::OFFSET_WIDTH-1:0] rd_start;
	logic [bres_pkg::OFFSET_WIDTH-1:0] rd_len;
	logic [bres_pkg::END_W-1:0]        ext_end;
	logic                              hit;
	logic                              done;
	logic [bres_pkg::END_W-1:0]        seg_end;
	logic                              last_ent;
	bres_pkg::result_t                 found_res;
	bres_pkg::result_t                 miss_res;

	always_comb begin
		n_next = (int'(count) > bres_pkg::TABLE_DEPTH) ?
			bres_pkg::N_W'(bres_pkg::TABLE_DEPTH) : bres_pkg::N_W'(count);
		issue    = (state_q == ST_SCAN) && (idx_q < n_q);
		rd_addr  = idx_q[bres_pkg::IDX_W-1:0];
		{rd_id, rd_start, rd_len} = rd_data;
		ext_end  = {1'b0, rd_start} + {1'b0, rd_len};
		hit      = (pos_q >= {1'b0, rd_start}) && (pos_q < ext_end);
		done     = (rend_q <= ext_end);
		seg_end  = (rend_q < ext_end) ? rend_q : ext_end;
		last_ent = (bres_pkg::N_W'(ent_s1) == (n_q - bres_pkg::N_W'(1)));

		found_res.seg_entry    = ent_s1;
		found_res.seg_block_id = rd_id;
		found_res.seg_start    = pos_q;
		found_res.seg_end      = seg_end;
		found_res.status       = bres_pkg::STATUS_FOUND;
		found_res.last         = done;

		miss_res.seg_entry    = '0;
		miss_res.seg_block_id = '0;
		miss_res.seg_start    = pos_q;
		miss_res.seg_end      = rend_q;
		miss_res.status       = bres_pkg::STATUS_NOT_FOUND;
		miss_res.last         = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						pos_q  <= {1'b0, range_start};
						rend_q <= {1'b0, range_start} + {1'b0, range_length};
						n_q    <= n_next;
						idx_q  <= '0;
						if (n_next == '0) begin
							res_q.seg_entry    <= '0;
							res_q.seg_block_id <= '0;
							res_q.seg_start    <= {1'b0, range_start};
							res_q.seg_end      <= {1'b0, range_start} + {1'b0, range_length};
							res_q.status       <= bres_pkg::STATUS_NOT_FOUND;
							res_q.last         <= 1'b1;
							state_q            <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1 && hit) begin
						res_q   <= found_res;
						vld_s1  <= 1'b0;
						state_q <= ST_EMIT;
					end else if (vld_s1 && last_ent) begin
						res_q   <= miss_res;
						vld_s1  <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						vld_s1 <= issue;
						if (issue) begin
							ent_s1 <= rd_addr;
							idx_q  <= idx_q + bres_pkg::N_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (res_take) begin
						if (res_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= res_q.seg_end;
							idx_q   <= '0;
							vld_s1  <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== src/byte_range_extent_splitter.sv =====
// top level: extent table ram, scan sequencer, config register, output register
// load transaction: written straight into the table ram
// split transaction: each scan pass reads up to n entries, one per cycle, and each result is
//   then handed to the output register once it can take it (n = clamped extent_count)
// one request at a time; a new one is taken once the last result sits in the output register
// reset clears control state and extent_count; table contents are undefined until written
`default_nettype none

module byte_range_extent_splitter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [bres_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [bres_pkg::ID_W-1:0]         entry_block_id,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] entry_start,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] entry_length,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] range_start,
	input  wire logic [bres_pkg::OFFSET_WIDTH-1:0] range_length,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [bres_pkg::IDX_W-1:0]        seg_entry,
	output logic      [bres_pkg::ID_W-1:0]         seg_block_id,
	output logic      [bres_pkg::END_W-1:0]        seg_start,
	output logic      [bres_pkg::END_W-1:0]        seg_end,
	output logic                                   status,
	output logic                                   last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bres_pkg::CFG_W-1:0]        cfg_data
);

	logic [bres_pkg::CFG_W-1:0]   extent_count_q;
	logic                         out_valid_q;
	bres_pkg::result_t            out_q;

	logic                         in_fire;
	logic                         load_we;
	logic                         scan_idle;
	logic [bres_pkg::IDX_W-1:0]   rd_addr;
	logic [bres_pkg::ENTRY_W-1:0] rd_data;
	logic                         res_valid;
	bres_pkg::result_t            res;
	logic                         res_take;

	assign in_stall  = !scan_idle;
	assign in_fire   = in_valid && !in_stall;
	assign load_we   = in_fire && (cmd == bres_pkg::CMD_LOAD) &&
		(int'(entry_index) < bres_pkg::TABLE_DEPTH);
	assign cfg_ready = 1'b1;
	assign res_take  = !out_valid_q || !out_stall;

	bres_ram #(
		.DEPTH(bres_pkg::TABLE_DEPTH),
		.WIDTH(bres_pkg::ENTRY_W),
		.AW   (bres_pkg::IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(entry_index),
		.wdata({entry_block_id, entry_start, entry_length}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	bres_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_fire && (cmd == bres_pkg::CMD_SPLIT)),
		.range_start (range_start),
		.range_length(range_length),
		.count       (extent_count_q),
		.idle        (scan_idle),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			extent_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign seg_entry    = out_q.seg_entry;
	assign seg_block_id = out_q.seg_block_id;
	assign seg_start    = out_q.seg_start;
	assign seg_end      = out_q.seg_end;
	assign status       = out_q.status;
	assign last         = out_q.last;

endmodule

`default_nettype wire

// ===== src/bres_checker.sv =====
// port level checker for the byte range extent splitter, bound to the top level
`default_nettype none

module bres_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       cmd,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [bres_pkg::END_W-1:0] seg_start,
	input wire logic [bres_pkg::END_W-1:0] seg_end,
	input wire logic                       status,
	input wire logic                       last
);

	// stalled result stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a split transaction makes the block busy
	a_split_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == bres_pkg::CMD_SPLIT) |=> in_stall)
		else $error("split transaction did not occupy the block");

	// not found always closes the request
	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bres_pkg::STATUS_NOT_FOUND) |-> last)
		else $error("not found result without last");

	// segments never run backwards
	a_seg_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (seg_start <= seg_end))
		else $error("segment start beyond segment end");

	// request still in progress while a non-final result is shown
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken in the middle of a split request");

endmodule

bind byte_range_extent_splitter bres_checker u_bres_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the byte range extent splitter: extent loads and range splits
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   TABLE_DEPTH      = bres_pkg::TABLE_DEPTH;
	localparam int   OFFSET_WIDTH     = bres_pkg::OFFSET_WIDTH;
	localparam int   ID_W             = bres_pkg::ID_W;
	localparam int   CFG_W            = bres_pkg::CFG_W;
	localparam int   END_W            = bres_pkg::END_W;
	localparam int   IDX_W            = bres_pkg::IDX_W;
	localparam logic CMD_LOAD         = bres_pkg::CMD_LOAD;
	localparam logic CMD_SPLIT        = bres_pkg::CMD_SPLIT;
	localparam logic STATUS_FOUND     = bres_pkg::STATUS_FOUND;
	localparam logic STATUS_NOT_FOUND = bres_pkg::STATUS_NOT_FOUND;

	typedef bres_pkg::result_t result_t;

	localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

	typedef struct {
		logic                    cmd;
		logic [IDX_W-1:0]        idx;
		logic [ID_W-1:0]         id;
		logic [OFFSET_WIDTH-1:0] ext_start;
		logic [OFFSET_WIDTH-1:0] ext_len;
		logic [OFFSET_WIDTH-1:0] rng_start;
		logic [OFFSET_WIDTH-1:0] rng_len;
	} table_op_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    in_valid       = 1'b0;
	logic                    in_stall;
	logic                    cmd            = CMD_LOAD;
	logic [IDX_W-1:0]        entry_index    = '0;
	logic [ID_W-1:0]         entry_block_id = '0;
	logic [OFFSET_WIDTH-1:0] entry_start    = '0;
	logic [OFFSET_WIDTH-1:0] entry_length   = '0;
	logic [OFFSET_WIDTH-1:0] range_start    = '0;
	logic [OFFSET_WIDTH-1:0] range_length   = '0;
	logic                    out_valid;
	logic                    out_stall      = 1'b0;
	logic [IDX_W-1:0]        seg_entry;
	logic [ID_W-1:0]         seg_block_id;
	logic [END_W-1:0]        seg_start;
	logic [END_W-1:0]        seg_end;
	logic                    status;
	logic                    last;
	logic                    cfg_valid      = 1'b0;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data       = '0;

	table_op_t pending_ops[$];
	result_t   expected_segments[$];
	result_t   monitor_want;

	// predictor copy of the extent table and the count register
	logic [ID_W-1:0]         tbl_id    [TABLE_DEPTH];
	logic [OFFSET_WIDTH-1:0] tbl_start [TABLE_DEPTH];
	logic [OFFSET_WIDTH-1:0] tbl_len   [TABLE_DEPTH];
	logic [CFG_W-1:0]        extent_count_copy = '0;

	// layout the stimulus aims its ranges at
	logic [OFFSET_WIDTH-1:0] plan_start [TABLE_DEPTH];
	logic [OFFSET_WIDTH-1:0] plan_len   [TABLE_DEPTH];

	int errors       = 0;
	int tx_gap       = 0;
	int rx_gap       = 0;
	int rx_next      = 0;
	int hold_left    = 0;
	bit hold_armed   = 1'b0;
	bit hold_done    = 1'b0;
	bit quiet        = 1'b0;

	byte_range_extent_splitter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.entry_index    (entry_index),
		.entry_block_id (entry_block_id),
		.entry_start    (entry_start),
		.entry_length   (entry_length),
		.range_start    (range_start),
		.range_length   (range_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.seg_entry      (seg_entry),
		.seg_block_id   (seg_block_id),
		.seg_start      (seg_start),
		.seg_end        (seg_end),
		.status         (status),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [ID_W-1:0] random_id();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [OFFSET_WIDTH-1:0] random_offset();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[OFFSET_WIDTH-1:0];
	endfunction

	function automatic void predict_segments(input logic [OFFSET_WIDTH-1:0] rs,
			input logic [OFFSET_WIDTH-1:0] rl);
		logic [END_W-1:0] pos;
		logic [END_W-1:0] rend;
		logic [END_W-1:0] ext_end;
		int unsigned      n;
		int               i;
		int               k;
		bit               hit;
		bit               done;
		result_t          r;
		n    = (extent_count_copy > TABLE_DEPTH) ? TABLE_DEPTH : extent_count_copy;
		pos  = END_W'(rs);
		rend = END_W'(rs) + END_W'(rl);
		k    = 0;
		hit  = 1'b1;
		done = 1'b0;
		while (hit && !done && k <= TABLE_DEPTH) begin
			hit = 1'b0;
			for (i = 0; i < n; i++) begin
				ext_end = END_W'(tbl_start[i]) + END_W'(tbl_len[i]);
				if (!hit && pos >= END_W'(tbl_start[i]) && pos < ext_end) begin
					hit            = 1'b1;
					done           = (rend <= ext_end);
					r.seg_entry    = IDX_W'(i);
					r.seg_block_id = tbl_id[i];
					r.seg_start    = pos;
					r.seg_end      = (rend < ext_end) ? rend : ext_end;
					r.status       = STATUS_FOUND;
					r.last         = done;
					expected_segments = {expected_segments, r};
					k++;
					pos = ext_end;
				end
			end
		end
		if (!done) begin
			r.seg_entry    = '0;
			r.seg_block_id = '0;
			r.seg_start    = pos;
			r.seg_end      = rend;
			r.status       = STATUS_NOT_FOUND;
			r.last         = 1'b1;
			expected_segments = {expected_segments, r};
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			if (cmd == CMD_LOAD) begin
				tbl_id[entry_index]    = entry_block_id;
				tbl_start[entry_index] = entry_start;
				tbl_len[entry_index]   = entry_length;
			end else begin
				predict_segments(range_start, range_length);
			end
		end
		if (!(in_valid && in_stall)) begin
			if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap   <= tx_gap - 1;
			end else if (pending_ops.size() != 0) begin
				table_op_t op;
				op = pending_ops.pop_front();
				cmd            <= op.cmd;
				entry_index    <= op.idx;
				entry_block_id <= op.id;
				entry_start    <= op.ext_start;
				entry_length   <= op.ext_len;
				range_start    <= op.rng_start;
				range_length   <= op.rng_len;
				in_valid       <= 1'b1;
				tx_gap         <= draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			rx_next = draw_gap();
		else
			rx_next = (rx_gap != 0) ? rx_gap - 1 : 0;
		rx_gap    <= rx_next;
		out_stall <= (rx_next != 0) || (hold_left != 0);
	end

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_segments.size() == 0) begin
				$error("unexpected transaction: entry %0d start %0h end %0h status %0b",
					seg_entry, seg_start, seg_end, status);
				errors++;
			end else begin
				monitor_want = expected_segments.pop_front();
				report_field("seg_entry", 64'(monitor_want.seg_entry), 64'(seg_entry));
				report_field("seg_block_id", monitor_want.seg_block_id, seg_block_id);
				report_field("seg_start", 64'(monitor_want.seg_start), 64'(seg_start));
				report_field("seg_end", 64'(monitor_want.seg_end), 64'(seg_end));
				report_field("status", 64'(monitor_want.status), 64'(status));
				report_field("last", 64'(monitor_want.last), 64'(last));
			end
		end
	end

	task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [ID_W-1:0] id,
			input logic [OFFSET_WIDTH-1:0] st, input logic [OFFSET_WIDTH-1:0] len);
		table_op_t op;
		op.cmd       = CMD_LOAD;
		op.idx       = idx;
		op.id        = id;
		op.ext_start = st;
		op.ext_len   = len;
		op.rng_start = random_offset();
		op.rng_len   = random_offset();
		pending_ops = {pending_ops, op};
		plan_start[idx] = st;
		plan_len[idx]   = len;
	endtask

	task automatic queue_split(input logic [OFFSET_WIDTH-1:0] rs,
			input logic [OFFSET_WIDTH-1:0] rl);
		table_op_t op;
		op.cmd       = CMD_SPLIT;
		op.idx       = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
		op.id        = random_id();
		op.ext_start = random_offset();
		op.ext_len   = random_offset();
		op.rng_start = rs;
		op.rng_len   = rl;
		pending_ops = {pending_ops, op};
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_segments.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_extent_count(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		extent_count_copy = value;
	endtask

	// all sixteen entries, shuffled over a run of adjacent, gapped or overlapping extents, or placed at random
	task automatic plan_table();
		int                      kind;
		int                      slot;
		int                      j;
		int                      tmp;
		int                      gap_pick;
		int                      order[TABLE_DEPTH];
		logic [OFFSET_WIDTH-1:0] cur;
		logic [OFFSET_WIDTH-1:0] st;
		logic [OFFSET_WIDTH-1:0] len;
		kind = $urandom_range(0, 3);
		for (slot = 0; slot < TABLE_DEPTH; slot++)
			order[slot] = slot;
		for (slot = TABLE_DEPTH - 1; slot > 0; slot--) begin
			j           = $urandom_range(0, slot);
			tmp         = order[slot];
			order[slot] = order[j];
			order[j]    = tmp;
		end
		if (kind == 0)
			cur = '0;
		else if (kind == 1)
			cur = random_offset();
		else
			cur = OFF_MAX - OFFSET_WIDTH'($urandom_range(0, 3000));
		for (slot = 0; slot < TABLE_DEPTH; slot++) begin
			if (kind == 3) begin
				st  = random_offset();
				len = random_offset();
			end else begin
				len      = ($urandom_range(0, 9) == 0) ? '0 : OFFSET_WIDTH'($urandom_range(1, 200));
				gap_pick = $urandom_range(0, 7);
				if (gap_pick == 0)
					st = cur + OFFSET_WIDTH'($urandom_range(1, 50));
				else if (gap_pick == 1)
					st = cur - OFFSET_WIDTH'($urandom_range(0, 100));
				else
					st = cur;
				cur = st + len;
			end
			queue_load(IDX_W'(order[slot]), random_id(), st, len);
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] count, input bit calm, input bit with_hold);
		int                      n;
		int                      pick;
		int                      j;
		logic [OFFSET_WIDTH-1:0] rs;
		logic [OFFSET_WIDTH-1:0] rl;
		wait_idle();
		write_extent_count(count);
		@(negedge clk);
		quiet = calm;
		plan_table();
		for (n = 0; n < 40; n++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				j = $urandom_range(0, TABLE_DEPTH - 1);
				queue_load(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), random_id(),
					plan_start[j] + OFFSET_WIDTH'($urandom_range(0, 100)),
					OFFSET_WIDTH'($urandom_range(0, 300)));
			end else if (pick <= 2) begin
				queue_split(random_offset(), random_offset());
			end else begin
				j  = $urandom_range(0, TABLE_DEPTH - 1);
				rs = plan_start[j];
				if (plan_len[j] != 0)
					rs = rs + (random_offset() % plan_len[j]);
				pick = $urandom_range(0, 7);
				if (pick == 0)
					rl = '0;
				else if (pick == 1)
					rl = random_offset();
				else if (pick <= 4)
					rl = OFFSET_WIDTH'($urandom_range(1, 400));
				else
					rl = OFFSET_WIDTH'($urandom_range(1, 4000));
				queue_split(rs, rl);
			end
		end
		hold_armed = with_hold;
	endtask

	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_extent_count('0);
		@(negedge clk);

		// adjacent extents from 1000, entry 5 empty, entry 14 overlapping, entry 15 at the top
		for (i = 0; i < 14; i++)
			queue_load(IDX_W'(i), (i == 0) ? '0 : random_id(), OFFSET_WIDTH'(1000 + 100 * i),
				(i == 5) ? '0 : OFFSET_WIDTH'(100));
		queue_load(IDX_W'(14), random_id(), OFFSET_WIDTH'(1450), OFFSET_WIDTH'(200));
		queue_load(IDX_W'(15), '1, OFF_MAX, OFF_MAX);
		// nothing searched with a count of zero
		queue_split(OFFSET_WIDTH'(1000), OFFSET_WIDTH'(100));

		wait_idle();
		write_extent_count(CFG_W'(TABLE_DEPTH));
		@(negedge clk);
		queue_split(OFFSET_WIDTH'(1000), OFFSET_WIDTH'(1400));
		queue_split(OFFSET_WIDTH'(1050), '0);
		queue_split(OFFSET_WIDTH'(500), '0);
		queue_split(OFFSET_WIDTH'(2350), OFFSET_WIDTH'(1000));
		queue_split(OFF_MAX, OFF_MAX);
		queue_split('0, OFF_MAX);
		queue_split(OFFSET_WIDTH'(1000), OFF_MAX);

		run_phase(CFG_W'(TABLE_DEPTH), 1'b0, 1'b0);
		run_phase('1, 1'b0, 1'b1);
		run_phase(CFG_W'(1), 1'b1, 1'b0);
		run_phase('0, 1'b0, 1'b0);
		run_phase(CFG_W'($urandom_range(2, TABLE_DEPTH - 1)), 1'b0, 1'b0);
		run_phase(CFG_W'(TABLE_DEPTH), 1'b1, 1'b0);
		run_phase(CFG_W'(20), 1'b0, 1'b0);
		run_phase(CFG_W'($urandom_range(0, 31)), 1'b0, 1'b0);

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/bres_pkg.sv
src/bres_ram.sv
src/bres_scan.sv
src/byte_range_extent_splitter.sv
src/bres_checker.sv
bench/testbench.sv
